/* sv/fmbs_pkg.sv */
// ----------------------------------------------------------------------------
// fmbs_pkg
// Shared types and constants of the FM-index backward search block.
// ----------------------------------------------------------------------------
`default_nettype none

package fmbs_pkg;

	localparam int NSYM    = 5;
	localparam int MATCH_W = 17;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_PATTERN = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	localparam logic [2:0] SYM_TERM = 3'd0;
	localparam logic [2:0] SYM_T    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OCC_START,
		S_QUOT,
		S_BASE,
		S_CORR,
		S_CKPT_RD,
		S_CKPT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_OCC_END
	} state_t;

endpackage

`default_nettype wire

/* sv/fmbs_text_store.sv */
// ----------------------------------------------------------------------------
// fmbs_text_store
// BWT symbol memory and occurrence checkpoint memory, both with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmbs_text_store import fmbs_pkg::*; #(
	parameter int ADDR_W = 16,
	parameter int LEN_W  = 17,
	parameter int NUM_CK = 8192,
	parameter int CK_W   = 13
) (
	input  wire logic                        clk,
	input  wire logic                        sym_we,
	input  wire logic [ADDR_W-1:0]           sym_waddr,
	input  wire logic [2:0]                  sym_wdata,
	input  wire logic [ADDR_W-1:0]           sym_raddr,
	output      logic [2:0]                  sym_rdata,
	input  wire logic                        ck_we,
	input  wire logic [CK_W-1:0]             ck_waddr,
	input  wire logic [NSYM-1:0][LEN_W-1:0]  ck_wdata,
	input  wire logic [CK_W-1:0]             ck_raddr,
	output      logic [NSYM-1:0][LEN_W-1:0]  ck_rdata
);

	logic [2:0]                 sym_mem [2**ADDR_W];
	logic [NSYM-1:0][LEN_W-1:0] ck_mem  [NUM_CK];

	always_ff @(posedge clk) begin
		if (sym_we) begin
			sym_mem[sym_waddr] <= sym_wdata;
		end
		sym_rdata <= sym_mem[sym_raddr];
	end

	always_ff @(posedge clk) begin
		if (ck_we) begin
			ck_mem[ck_waddr] <= ck_wdata;
		end
		ck_rdata <= ck_mem[ck_raddr];
	end

endmodule

`default_nettype wire

/* sv/fm_index_backward_search_top.sv */
// ----------------------------------------------------------------------------
// fm_index_backward_search_top
// FM-index backward search over a BWT text on {terminator, A, C, G, T}.
// ----------------------------------------------------------------------------
// Clear, append and no-op commands never raise busy. A pattern symbol that
// does not narrow an active range does not raise busy either, and its result
// strobe follows in the next cycle. A narrowing step keeps busy high for two occ
// lookups on the shared sequencer; the result strobe comes in the first cycle
// after busy falls.
// Reset clears all counters and the query; memory contents are not cleared.
`default_nettype none

module fm_index_backward_search_top import fmbs_pkg::*; #(
	parameter int TEXT_DEPTH          = 65536,
	parameter int CHECKPOINT_INTERVAL = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	input  wire logic [1:0]         opcode,
	input  wire logic [2:0]         symbol,
	input  wire logic               pattern_end,
	output      logic               done,
	output      logic [MATCH_W-1:0] match_count,
	output      logic               bad_symbol
);

	localparam int LEN_W  = $clog2(TEXT_DEPTH + 1);
	localparam int ADDR_W = $clog2(TEXT_DEPTH);
	localparam int NUM_CK = (TEXT_DEPTH + CHECKPOINT_INTERVAL - 1) / CHECKPOINT_INTERVAL;
	localparam int CK_W   = (NUM_CK > 1) ? $clog2(NUM_CK) : 1;
	localparam int BLK_W  = $clog2(CHECKPOINT_INTERVAL + 1);
	localparam int PROD_W = 2 * LEN_W + 1;
	localparam logic [LEN_W:0]     RECIP  = (LEN_W+1)'((2**LEN_W) / CHECKPOINT_INTERVAL);
	localparam logic [LEN_W-1:0]   CI_L   = LEN_W'(CHECKPOINT_INTERVAL);
	localparam logic [BLK_W-1:0]   BLK_LAST = BLK_W'(CHECKPOINT_INTERVAL - 1);
	localparam logic [LEN_W-1:0]   DEPTH_L  = LEN_W'(TEXT_DEPTH);

	state_t state_q, state_d;

	logic [NSYM-1:0][LEN_W-1:0] totals_q;
	logic [NSYM-1:0][LEN_W-1:0] ctab_q;
	logic [LEN_W-1:0]  len_q;
	logic [BLK_W-1:0]  blk_q;
	logic [CK_W-1:0]   ckw_q;
	logic [LEN_W-1:0]  range_low_q, range_high_q;
	logic              active_q, err_q;

	logic [2:0]        sym_q;
	logic              fin_q, phase_q;
	logic [LEN_W-1:0]  i_q, k_q, start_q, p_q, occ_q, occ_lo_q;
	logic [PROD_W-1:0] prod_q;

	logic              done_q, bad_q;
	logic [MATCH_W-1:0] match_q;

	logic [2:0]                 sym_rdata;
	logic [NSYM-1:0][LEN_W-1:0] ck_rdata;

	logic accept, sym_ok, do_append, narrow;
	logic [LEN_W-1:0] cv_in, cv_q, fin_lo, fin_hi;

	assign accept    = start && !busy;
	assign sym_ok    = (symbol <= SYM_T);
	assign do_append = accept && (opcode == OP_APPEND) && sym_ok && (len_q < DEPTH_L);
	assign narrow    = sym_ok && active_q && (range_low_q < range_high_q);
	assign cv_in     = ctab_q[symbol];
	assign cv_q      = ctab_q[sym_q];
	assign fin_lo    = cv_q + occ_lo_q;
	assign fin_hi    = cv_q + occ_q;

	fmbs_text_store #(
		.ADDR_W (ADDR_W),
		.LEN_W  (LEN_W),
		.NUM_CK (NUM_CK),
		.CK_W   (CK_W)
	) u_store (
		.clk       (clk),
		.sym_we    (do_append),
		.sym_waddr (len_q[ADDR_W-1:0]),
		.sym_wdata (symbol),
		.sym_raddr (p_q[ADDR_W-1:0]),
		.sym_rdata (sym_rdata),
		.ck_we     (do_append && (blk_q == '0)),
		.ck_waddr  (ckw_q),
		.ck_wdata  (totals_q),
		.ck_raddr  (k_q[CK_W-1:0]),
		.ck_rdata  (ck_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (accept && (opcode == OP_PATTERN) && narrow) begin
					state_d = S_OCC_START;
				end
			end
			S_OCC_START: begin
				state_d = (i_q >= len_q) ? S_OCC_END : S_QUOT;
			end
			S_QUOT:    state_d = S_BASE;
			S_BASE:    state_d = S_CORR;
			S_CORR:    state_d = S_CKPT_RD;
			S_CKPT_RD: state_d = S_CKPT;
			S_CKPT:    state_d = S_SCAN_RD;
			S_SCAN_RD: state_d = S_SCAN_CMP;
			S_SCAN_CMP: begin
				state_d = (p_q < i_q) ? S_SCAN_RD : S_OCC_END;
			end
			S_OCC_END: begin
				state_d = phase_q ? S_IDLE : S_OCC_START;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Text bookkeeping, query range and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			totals_q     <= '0;
			ctab_q       <= '0;
			len_q        <= '0;
			blk_q        <= '0;
			ckw_q        <= '0;
			range_low_q  <= '0;
			range_high_q <= '0;
			active_q     <= 1'b0;
			err_q        <= 1'b0;
			fin_q        <= 1'b0;
			phase_q      <= 1'b0;
			done_q       <= 1'b0;
			bad_q        <= 1'b0;
			match_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				case (opcode_t'(opcode))
					OP_CLEAR: begin
						totals_q     <= '0;
						ctab_q       <= '0;
						len_q        <= '0;
						blk_q        <= '0;
						ckw_q        <= '0;
						range_low_q  <= '0;
						range_high_q <= '0;
						active_q     <= 1'b0;
						err_q        <= 1'b0;
					end
					OP_APPEND: begin
						if (!sym_ok) begin
							err_q <= 1'b1;
						end else if (do_append) begin
							totals_q[symbol] <= totals_q[symbol] + 1'b1;
							for (int c = 1; c < NSYM; c++) begin
								if (3'(c) > symbol) begin
									ctab_q[c] <= ctab_q[c] + 1'b1;
								end
							end
							len_q <= len_q + 1'b1;
							blk_q <= (blk_q == BLK_LAST) ? '0 : blk_q + 1'b1;
							if (blk_q == '0) begin
								ckw_q <= ckw_q + 1'b1;
							end
						end
					end
					OP_PATTERN: begin
						if (narrow) begin
							fin_q   <= pattern_end;
							phase_q <= 1'b0;
						end else if (pattern_end) begin
							done_q       <= 1'b1;
							bad_q        <= err_q || !sym_ok;
							if (sym_ok && !active_q) begin
								match_q <= MATCH_W'(totals_q[symbol]);
							end else if (active_q && (range_high_q > range_low_q)) begin
								match_q <= MATCH_W'(range_high_q - range_low_q);
							end else begin
								match_q <= '0;
							end
							err_q        <= 1'b0;
							active_q     <= 1'b0;
							range_low_q  <= '0;
							range_high_q <= '0;
						end else if (!sym_ok) begin
							err_q <= 1'b1;
						end else if (!active_q) begin
							range_low_q  <= cv_in;
							range_high_q <= cv_in + totals_q[symbol];
							active_q     <= 1'b1;
						end
					end
					default: ;
				endcase
			end else if (state_q == S_OCC_END) begin
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else if (fin_q) begin
					done_q       <= 1'b1;
					bad_q        <= err_q;
					match_q      <= (fin_hi > fin_lo) ? MATCH_W'(fin_hi - fin_lo) : '0;
					err_q        <= 1'b0;
					active_q     <= 1'b0;
					range_low_q  <= '0;
					range_high_q <= '0;
				end else begin
					range_low_q  <= fin_lo;
					range_high_q <= fin_hi;
				end
			end
		end
	end

	// Occ datapath: reciprocal divide, checkpoint read, block scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= symbol;
			i_q   <= range_low_q;
		end
		case (state_q)
			S_OCC_START: begin
				occ_q  <= totals_q[sym_q];
				prod_q <= {{(LEN_W+1){1'b0}}, i_q} * {{LEN_W{1'b0}}, RECIP};
			end
			S_QUOT: k_q <= prod_q[2*LEN_W-1:LEN_W];
			S_BASE: start_q <= LEN_W'(k_q * CI_L);
			S_CORR: begin
				// The reciprocal estimate may fall one block short.
				if ((i_q - start_q) >= CI_L) begin
					k_q     <= k_q + 1'b1;
					start_q <= start_q + CI_L;
				end
			end
			S_CKPT: begin
				occ_q <= ck_rdata[sym_q];
				p_q   <= start_q;
			end
			S_SCAN_CMP: begin
				if (p_q < i_q) begin
					if (sym_rdata == sym_q) begin
						occ_q <= occ_q + 1'b1;
					end
					p_q <= p_q + 1'b1;
				end
			end
			S_OCC_END: begin
				if (!phase_q) begin
					occ_lo_q <= occ_q;
					i_q      <= range_high_q;
				end
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign match_count = match_q;
	assign bad_symbol  = bad_q;

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (32'(match_q) <= 32'(len_q)))
		else $error("match count exceeds text length");

	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (range_low_q <= range_high_q))
		else $error("suffix range inverted");

	a_scan_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN_CMP) |-> ((p_q <= i_q) && ((p_q - start_q) < CI_L)))
		else $error("block scan left its checkpoint block");

	a_busy_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(len_q))
		else $error("text changed during a lookup");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FM-index backward search block: loads random
// BWT texts, runs pattern queries against them and compares every count.
// ----------------------------------------------------------------------------
`default_nettype none

import fmbs_pkg::*;

class search_scoreboard;
	localparam int DEPTH = 65536;
	localparam int INTERVAL = 8;

	logic [2:0]  text [DEPTH];
	int unsigned ckpt [4][DEPTH/INTERVAL];
	int unsigned totals [NSYM];
	int unsigned text_len;
	int unsigned lo_bound, hi_bound;
	bit          in_query;
	bit          saw_bad;
	int unsigned counts_q [$];
	bit          bad_q [$];
	int          errors;
	int          results_seen;
	int          hits_seen;

	function new();
		errors = 0;
		results_seen = 0;
		hits_seen = 0;
		wipe();
	endfunction

	function void wipe();
		foreach (totals[k]) totals[k] = 0;
		text_len = 0;
		lo_bound = 0;
		hi_bound = 0;
		in_query = 1'b0;
		saw_bad = 1'b0;
	endfunction

	function int unsigned sym_base(int unsigned c);
		int unsigned s;
		s = 0;
		for (int k = 0; k < c; k++) s += totals[k];
		return s;
	endfunction

	// Rank of symbol c in text[0..i): checkpoint plus a scan of the block tail.
	function int unsigned rank(int unsigned c, int unsigned i);
		int unsigned k, first, r;
		if (i >= text_len) return totals[c];
		k = i / INTERVAL;
		first = k * INTERVAL;
		if (c == SYM_TERM)
			r = first - ckpt[0][k] - ckpt[1][k] - ckpt[2][k] - ckpt[3][k];
		else
			r = ckpt[c-1][k];
		for (int unsigned p = first; p < i; p++)
			if (text[p] == c) r++;
		return r;
	endfunction

	function int pending();
		return counts_q.size();
	endfunction

	function void note_command(opcode_t op, logic [2:0] sym, logic fin);
		int unsigned cv, nlo, nhi;
		bit ok;
		ok = (sym <= SYM_T);
		case (op)
			OP_CLEAR: wipe();
			OP_APPEND: begin
				if (!ok) saw_bad = 1'b1;
				else if (text_len < DEPTH) begin
					if (text_len % INTERVAL == 0)
						for (int j = 0; j < 4; j++) ckpt[j][text_len/INTERVAL] = totals[j+1];
					text[text_len] = sym;
					totals[sym]++;
					text_len++;
				end
			end
			OP_PATTERN: begin
				if (!ok) saw_bad = 1'b1;
				else if (!in_query) begin
					lo_bound = sym_base(sym);
					hi_bound = lo_bound + totals[sym];
					in_query = 1'b1;
				end else if (lo_bound < hi_bound) begin
					cv = sym_base(sym);
					nlo = cv + rank(sym, lo_bound);
					nhi = cv + rank(sym, hi_bound);
					lo_bound = nlo;
					hi_bound = nhi;
				end
				if (fin) begin
					counts_q = {counts_q, ((in_query && hi_bound > lo_bound) ?
						((hi_bound - lo_bound) & 32'h1FFFF) : 32'd0)};
					bad_q = {bad_q, saw_bad};
					saw_bad = 1'b0;
					in_query = 1'b0;
					lo_bound = 0;
					hi_bound = 0;
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(logic [MATCH_W-1:0] cnt, logic bad);
		int unsigned exp_cnt;
		bit exp_bad;
		if (counts_q.size() == 0) begin
			$error("result strobe with no query outstanding: match_count=%0d", cnt);
			errors++;
			return;
		end
		exp_cnt = counts_q.pop_front();
		exp_bad = bad_q.pop_front();
		results_seen++;
		if (exp_cnt != 0) hits_seen++;
		if (cnt !== exp_cnt[MATCH_W-1:0]) begin
			$error("match_count: expected %0d, got %0d", exp_cnt, cnt);
			errors++;
		end
		if (bad !== exp_bad) begin
			$error("bad_symbol: expected %0b, got %0b", exp_bad, bad);
			errors++;
		end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         opcode;
	logic [2:0]         symbol;
	logic               pattern_end;
	logic               done;
	logic [MATCH_W-1:0] match_count;
	logic               bad_symbol;

	search_scoreboard sb;
	int               xfer_count;
	int               appends_sent;
	bit               no_gaps;

	fm_index_backward_search_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .symbol(symbol), .pattern_end(pattern_end),
		.done(done), .match_count(match_count), .bad_symbol(bad_symbol)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("fm_index_backward_search_top verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_command(opcode_t'(opcode), symbol, pattern_end);
				xfer_count++;
			end
			if (done) sb.check_result(match_count, bad_symbol);
		end
	end

	// Called at a falling edge; returns at a falling edge after the transfer.
	task automatic send(opcode_t op, logic [2:0] sym, logic fin);
		int prev, gap, r;
		prev = xfer_count;
		start = 1'b1;
		opcode = op;
		symbol = sym;
		pattern_end = fin;
		do @(negedge clk); while (xfer_count == prev);
		if (op == OP_APPEND) appends_sent++;
		r = $urandom_range(0, 99);
		gap = no_gaps ? 0 : (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) :
			$urandom_range(10, 40);
		if (gap > 0) begin
			start = 1'b0;
			opcode = opcode_t'($urandom_range(0, 3));
			symbol = 3'($urandom_range(0, 7));
			pattern_end = 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [2:0] pick_symbol();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return 3'($urandom_range(1, 4));
		if (r < 93) return SYM_TERM;
		return 3'($urandom_range(5, 7));
	endfunction

	task automatic load_text(int len, bit with_bad);
		for (int i = 0; i < len; i++)
			send(OP_APPEND, (with_bad && $urandom_range(0, 29) == 0) ?
				3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
				1'($urandom_range(0, 1)));
	endtask

	task automatic run_query(int len);
		int r;
		for (int j = 0; j < len; j++) begin
			r = $urandom_range(0, 99);
			if (r < 4) send(OP_NOP, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			else if (r < 8) send(OP_APPEND, 3'($urandom_range(0, 4)), 1'b0);
			send(OP_PATTERN, pick_symbol(), j == len - 1);
		end
	endtask

	initial begin
		int guard;
		sb = new();
		xfer_count = 0;
		appends_sent = 0;
		no_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_NOP;
		symbol = SYM_TERM;
		pattern_end = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: queries on an empty text, invalid symbols, opcode three.
		send(OP_PATTERN, 3'd1, 1'b1);
		send(OP_PATTERN, 3'd7, 1'b1);
		send(OP_NOP, 3'd5, 1'b1);
		send(OP_APPEND, 3'd6, 1'b0);
		send(OP_PATTERN, SYM_T, 1'b1);
		// A short text holding every symbol, then walks across block borders.
		for (int i = 0; i < 19; i++) send(OP_APPEND, 3'(i % 5), 1'b0);
		send(OP_PATTERN, SYM_T, 1'b0);
		send(OP_PATTERN, 3'd5, 1'b0);
		send(OP_PATTERN, SYM_TERM, 1'b0);
		send(OP_PATTERN, 3'd2, 1'b1);
		send(OP_PATTERN, 3'd1, 1'b0);
		send(OP_APPEND, 3'd1, 1'b0);
		send(OP_PATTERN, 3'd1, 1'b0);
		send(OP_PATTERN, 3'd1, 1'b1);
		send(OP_CLEAR, 3'd7, 1'b1);
		send(OP_PATTERN, 3'd3, 1'b1);

		// Random phases: fresh text, then a run of queries, with noise.
		while (xfer_count < 1200) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			send(OP_CLEAR, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
			load_text($urandom_range(1, 70), 1'b1);
			repeat ($urandom_range(3, 10)) run_query($urandom_range(1, 5));
		end

		// Single-symbol queries over the last text, then a few more queries.
		no_gaps = 1'b0;
		for (int s = 0; s <= 4; s++) send(OP_PATTERN, 3'(s), 1'b1);
		repeat (8) run_query($urandom_range(1, 4));

		start = 1'b0;
		guard = 0;
		while (sb.pending() > 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (60) @(negedge clk);
		if (sb.pending() > 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		$display("Covered %0d transfers (%0d appends), %0d query results, %0d non-zero.",
			xfer_count, appends_sent, sb.results_seen, sb.hits_seen);
		if (sb.errors == 0)
			$display("fm_index_backward_search_top verification clean");
		else
			$display("fm_index_backward_search_top verification failed");
		$finish;
	end
endmodule

`default_nettype wire
